FILE: sv/rbd_pkg.sv
// Package for the ring buffer deque: sizes, operation codes, beat and control types.
// No dependencies; used by rbd_ctrl, rbd_dp and ring_buffer_deque.
package rbd_pkg;

	localparam int DEPTH   = 64;
	localparam int DATA_W  = 64;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int MODE_W  = 3;
	localparam int INDEX_W = 6;
	localparam int SUM_W   = ((PTR_W > INDEX_W) ? PTR_W : INDEX_W) + 1;

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ_AT    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd5;

	localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(DEPTH);

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [63:0]        value;
		logic [INDEX_W-1:0] index;
	} cmd_t;

	typedef struct packed {
		logic [63:0]       data;
		logic              ok;
		logic [CNT_W-1:0]  count;
		logic              empty_res;
		logic              full_res;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic resp;
		logic busy;
	} ctl_t;

endpackage

FILE: sv/rbd_ctrl.sv
// Controller for the ring buffer deque: sequences load, execute and response.
// Depends on rbd_pkg.
module rbd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output rbd_pkg::ctl_t ctl
);

	rbd_pkg::state_t state_q;
	rbd_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rbd_pkg::ST_IDLE: begin
				if (start) state_d = rbd_pkg::ST_EXEC;
			end
			rbd_pkg::ST_EXEC: begin
				state_d = rbd_pkg::ST_RESP;
			end
			rbd_pkg::ST_RESP: begin
				state_d = rbd_pkg::ST_IDLE;
			end
			default: begin
				state_d = rbd_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			rbd_pkg::ST_IDLE: begin
				ctl.load = start;
			end
			rbd_pkg::ST_EXEC: begin
				ctl.exec = 1'b1;
				ctl.busy = 1'b1;
			end
			rbd_pkg::ST_RESP: begin
				ctl.resp = 1'b1;
				ctl.busy = 1'b1;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule

FILE: sv/rbd_dp.sv
// Datapath for the ring buffer deque: pointers, fill count and the element store.
// Depends on rbd_pkg; driven by rbd_ctrl through rbd_pkg::ctl_t.
module rbd_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  rbd_pkg::ctl_t ctl,
	input  rbd_pkg::cmd_t cmd,
	output rbd_pkg::res_t res
);

	logic [rbd_pkg::DATA_W-1:0] mem [rbd_pkg::DEPTH];

	rbd_pkg::cmd_t              cmd_q;
	logic [rbd_pkg::PTR_W-1:0]  head_q;
	logic [rbd_pkg::PTR_W-1:0]  tail_q;
	logic [rbd_pkg::CNT_W-1:0]  cnt_q;
	logic [rbd_pkg::DATA_W-1:0] rd_q;
	logic                       rd_sel_q;
	logic                       ok_q;

	logic                       not_full;
	logic                       not_empty;
	logic [rbd_pkg::PTR_W-1:0]  head_dec;
	logic [rbd_pkg::PTR_W-1:0]  head_inc;
	logic [rbd_pkg::PTR_W-1:0]  tail_dec;
	logic [rbd_pkg::PTR_W-1:0]  tail_inc;
	logic [rbd_pkg::SUM_W-1:0]  pos_sum;
	logic [rbd_pkg::PTR_W-1:0]  pos_addr;
	logic                       idx_ok;
	logic [rbd_pkg::PTR_W-1:0]  addr;
	logic                       we;
	logic                       re;
	logic                       ok;

	assign not_full  = (cnt_q != rbd_pkg::CNT_FULL);
	assign not_empty = (cnt_q != '0);
	assign head_dec  = (head_q == '0) ? rbd_pkg::PTR_LAST : head_q - 1'b1;
	assign head_inc  = (head_q == rbd_pkg::PTR_LAST) ? '0 : head_q + 1'b1;
	assign tail_dec  = (tail_q == '0) ? rbd_pkg::PTR_LAST : tail_q - 1'b1;
	assign tail_inc  = (tail_q == rbd_pkg::PTR_LAST) ? '0 : tail_q + 1'b1;

	// position from the head, wrapped once round the ring
	assign pos_sum  = rbd_pkg::SUM_W'(head_q) + rbd_pkg::SUM_W'(cmd_q.index);
	assign pos_addr = (pos_sum >= rbd_pkg::SUM_W'(rbd_pkg::DEPTH))
		? rbd_pkg::PTR_W'(pos_sum - rbd_pkg::SUM_W'(rbd_pkg::DEPTH))
		: rbd_pkg::PTR_W'(pos_sum);
	assign idx_ok   = (rbd_pkg::SUM_W'(cmd_q.index) < rbd_pkg::SUM_W'(cnt_q));

	always_comb begin
		addr = head_q;
		we   = 1'b0;
		re   = 1'b0;
		ok   = 1'b0;
		case (cmd_q.mode)
			rbd_pkg::MODE_PUSH_FRONT: begin
				addr = head_dec;
				we   = not_full;
				ok   = not_full;
			end
			rbd_pkg::MODE_PUSH_BACK: begin
				addr = tail_q;
				we   = not_full;
				ok   = not_full;
			end
			rbd_pkg::MODE_POP_FRONT: begin
				addr = head_q;
				re   = not_empty;
				ok   = not_empty;
			end
			rbd_pkg::MODE_POP_BACK: begin
				addr = tail_dec;
				re   = not_empty;
				ok   = not_empty;
			end
			rbd_pkg::MODE_READ_AT: begin
				addr = pos_addr;
				re   = idx_ok;
				ok   = idx_ok;
			end
			rbd_pkg::MODE_CLEAR: begin
				ok = 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// store: one write or one registered read per operation
	always_ff @(posedge clk) begin
		if (ctl.exec && we) mem[addr] <= cmd_q.value[rbd_pkg::DATA_W-1:0];
		if (ctl.exec && re) rd_q <= mem[addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.load) cmd_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			cnt_q    <= '0;
			rd_sel_q <= 1'b0;
			ok_q     <= 1'b0;
		end else if (ctl.exec) begin
			rd_sel_q <= re;
			ok_q     <= ok;
			case (cmd_q.mode)
				rbd_pkg::MODE_PUSH_FRONT: begin
					if (not_full) begin
						head_q <= head_dec;
						cnt_q  <= cnt_q + 1'b1;
					end
				end
				rbd_pkg::MODE_PUSH_BACK: begin
					if (not_full) begin
						tail_q <= tail_inc;
						cnt_q  <= cnt_q + 1'b1;
					end
				end
				rbd_pkg::MODE_POP_FRONT: begin
					if (not_empty) begin
						head_q <= head_inc;
						cnt_q  <= cnt_q - 1'b1;
					end
				end
				rbd_pkg::MODE_POP_BACK: begin
					if (not_empty) begin
						tail_q <= tail_dec;
						cnt_q  <= cnt_q - 1'b1;
					end
				end
				rbd_pkg::MODE_CLEAR: begin
					head_q <= '0;
					tail_q <= '0;
					cnt_q  <= '0;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_comb begin
		res.data      = rd_sel_q ? 64'(rd_q) : 64'd0;
		res.ok        = ok_q;
		res.count     = cnt_q;
		res.empty_res = (cnt_q == '0);
		res.full_res  = (cnt_q == rbd_pkg::CNT_FULL);
	end

endmodule

FILE: sv/ring_buffer_deque.sv
// Ring buffer deque: each beat is one operation, accepted (load) when start is seen
// while busy is low; it then passes the execute and respond states, and its result beat
// is strobed by done for exactly one cycle. The next operation is accepted only after
// that result has gone out; the single-port store's read data is registered.
// Reset (arst_n low, asynchronous) zeroes head, tail and count; the store is not cleared
// and needs no clearing pass. The receiver cannot stall a result.
module ring_buffer_deque (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rbd_pkg::cmd_t cmd,
	output logic          done,
	output rbd_pkg::res_t res
);

	rbd_pkg::ctl_t ctl;

	// controller: hold off new beats until the current result has gone out
	rbd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.ctl    (ctl)
	);

	// datapath: capture the beat, advance the pointers, access the store once
	rbd_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (cmd),
		.res    (res)
	);

	assign busy = ctl.busy;
	assign done = ctl.resp;

endmodule
